FILE: hdl/scpd_pkg.sv
// ----------------------------------------------------------------------------
// scpd_pkg
// types and constants shared by the serial commanded phase dimmer
// ----------------------------------------------------------------------------
package scpd_pkg;

  localparam int unsigned DelayBits = 14;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ZC   = 2'd1;
  localparam logic [1:0] CMD_BYTE = 2'd2;

  localparam logic [DelayBits-1:0] FULL_SCALE  = 14'd9300;
  localparam logic [DelayBits-1:0] RESET_DELAY = 14'd9000;
  localparam logic [7:0]           RESET_PULSE = 8'd10;

  localparam logic [7:0] CHAR_L     = 8'h4C;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_UB    = 8'h42;
  localparam logic [7:0] CHAR_LB    = 8'h62;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic                 gate;
    logic                 relay_one;
    logic                 relay_two;
    logic [DelayBits-1:0] delay_now;
    logic                 firing_busy;
  } out_item_t;

  typedef struct packed {
    logic                 relay_one;
    logic                 relay_two;
    logic [DelayBits-1:0] delay;
  } ctl_sts_t;

  typedef struct packed {
    logic gate;
    logic busy;
  } tmr_sts_t;

endpackage

FILE: hdl/scpd_parser.sv
// ----------------------------------------------------------------------------
// scpd_parser
// command line parser: relay commands and dimming level with atol parsing
// ----------------------------------------------------------------------------
module scpd_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            byte_en_i,
  input  logic [7:0]                      byte_i,
  output logic [scpd_pkg::DelayBits-1:0]  delay_q_o,
  output scpd_pkg::ctl_sts_t              sts_d_o
);
  import scpd_pkg::*;

  localparam logic [1:0] NUM_SKIP  = 2'd0;
  localparam logic [1:0] NUM_DIGIT = 2'd1;
  localparam logic [1:0] NUM_DONE  = 2'd2;

  logic [DelayBits-1:0] delay_q, delay_d;
  logic                 relay_one_q, relay_one_d;
  logic                 relay_two_q, relay_two_d;
  logic [7:0]           line_cmd_q, line_cmd_d;
  logic                 line_start_q, line_start_d;
  logic [1:0]           num_phase_q, num_phase_d;
  logic                 num_neg_q, num_neg_d;
  logic [DelayBits-1:0] num_val_q, num_val_d;

  logic                 is_digit;
  logic                 is_space;
  logic [16:0]          acc;
  logic [DelayBits-1:0] acc_sat;
  logic [DelayBits-1:0] level;

  assign is_digit = byte_i inside {[CHAR_ZERO:CHAR_NINE]};
  assign is_space = byte_i inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE};
  assign acc      = 17'(num_val_q) * 17'd10 + 17'(byte_i - CHAR_ZERO);
  assign acc_sat  = (acc > 17'(FULL_SCALE)) ? FULL_SCALE : acc[DelayBits-1:0];
  assign level    = num_neg_q ? '0 : num_val_q;

  always_comb begin
    delay_d      = delay_q;
    relay_one_d  = relay_one_q;
    relay_two_d  = relay_two_q;
    line_cmd_d   = line_cmd_q;
    line_start_d = line_start_q;
    num_phase_d  = num_phase_q;
    num_neg_d    = num_neg_q;
    num_val_d    = num_val_q;
    if (byte_en_i) begin
      if (byte_i == CHAR_NL) begin
        if (!line_start_q) begin
          case (line_cmd_q)
            CHAR_L:  delay_d = FULL_SCALE - level;
            CHAR_UA: relay_two_d = 1'b1;
            CHAR_LA: relay_two_d = 1'b0;
            CHAR_UB: relay_one_d = 1'b1;
            CHAR_LB: relay_one_d = 1'b0;
            default: ;
          endcase
        end
        line_cmd_d   = '0;
        line_start_d = 1'b1;
        num_phase_d  = NUM_SKIP;
        num_neg_d    = 1'b0;
        num_val_d    = '0;
      end else if (line_start_q) begin
        line_cmd_d   = byte_i;
        line_start_d = 1'b0;
      end else begin
        case (num_phase_q)
          NUM_SKIP: begin
            if (is_space) begin
              num_phase_d = NUM_SKIP;
            end else if (byte_i == CHAR_PLUS || byte_i == CHAR_MINUS) begin
              num_neg_d   = (byte_i == CHAR_MINUS);
              num_phase_d = NUM_DIGIT;
            end else if (!is_digit) begin
              num_phase_d = NUM_DONE;
            end else begin
              num_phase_d = NUM_DIGIT;
              num_val_d   = acc_sat;
            end
          end
          NUM_DIGIT: begin
            if (!is_digit) begin
              num_phase_d = NUM_DONE;
            end else begin
              num_val_d = acc_sat;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q      <= RESET_DELAY;
      relay_one_q  <= 1'b0;
      relay_two_q  <= 1'b0;
      line_cmd_q   <= '0;
      line_start_q <= 1'b1;
      num_phase_q  <= NUM_SKIP;
      num_neg_q    <= 1'b0;
      num_val_q    <= '0;
    end else begin
      delay_q      <= delay_d;
      relay_one_q  <= relay_one_d;
      relay_two_q  <= relay_two_d;
      line_cmd_q   <= line_cmd_d;
      line_start_q <= line_start_d;
      num_phase_q  <= num_phase_d;
      num_neg_q    <= num_neg_d;
      num_val_q    <= num_val_d;
    end
  end

  assign delay_q_o         = delay_q;
  assign sts_d_o.relay_one = relay_one_d;
  assign sts_d_o.relay_two = relay_two_d;
  assign sts_d_o.delay     = delay_d;

endmodule

FILE: hdl/scpd_timer.sv
// ----------------------------------------------------------------------------
// scpd_timer
// zero-cross armed delay counter and gate pulse generator
// ----------------------------------------------------------------------------
module scpd_timer #(
  parameter int unsigned COUNT_BITS = 14
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            tick_en_i,
  input  logic                            zc_en_i,
  input  logic [scpd_pkg::DelayBits-1:0]  delay_i,
  input  logic [7:0]                      width_i,
  output scpd_pkg::tmr_sts_t              sts_d_o
);
  import scpd_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_WAIT  = 2'd1;
  localparam logic [1:0] PH_PULSE = 2'd2;

  localparam int unsigned CmpBits = (COUNT_BITS > DelayBits) ? COUNT_BITS : DelayBits;
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  logic [1:0]            phase_q, phase_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [7:0]            width;
  logic                  cnt_sat;
  logic                  hit_delay;
  logic                  hit_width;

  assign width     = (width_i == '0) ? 8'd1 : width_i;
  assign cnt_inc   = (cnt_q == CountMax) ? cnt_q : cnt_q + 1'b1;
  assign cnt_sat   = (cnt_inc == CountMax);
  assign hit_delay = (CmpBits'(cnt_inc) >= CmpBits'(delay_i)) || cnt_sat;
  assign hit_width = (CmpBits'(cnt_inc) >= CmpBits'(width)) || cnt_sat;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    if (tick_en_i) begin
      case (phase_q)
        PH_WAIT: begin
          if (hit_delay) begin
            phase_d = PH_PULSE;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        PH_PULSE: begin
          if (hit_width) begin
            phase_d = PH_IDLE;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        default: ;
      endcase
    end else if (zc_en_i && phase_q == PH_IDLE) begin
      phase_d = PH_WAIT;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  assign sts_d_o.gate = (phase_d == PH_PULSE);
  assign sts_d_o.busy = (phase_d != PH_IDLE);

endmodule

FILE: hdl/serial_commanded_phase_dimmer.sv
// ----------------------------------------------------------------------------
// serial_commanded_phase_dimmer
// serial command parser, relay control and triac phase angle firing timer
// ----------------------------------------------------------------------------
// path: each input transfer passes the input register, then the result register
// throughput: one item per cycle while the output is not stalled, set by the single input and result register
// every item gives one result showing the state after that item
// reset: async active low; delay 9000, relays off, timer idle, pulse width 10
// ----------------------------------------------------------------------------
module serial_commanded_phase_dimmer #(
  parameter int unsigned COUNT_BITS = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  scpd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output scpd_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i
);
  import scpd_pkg::*;

  logic                 in_vld_q;
  in_item_t             in_q;
  logic                 out_vld_q;
  out_item_t            out_q;
  logic [7:0]           width_q;
  logic                 adv;
  logic                 in_take;
  logic [DelayBits-1:0] delay_q;
  ctl_sts_t             ctl_d;
  tmr_sts_t             tmr_d;

  assign adv         = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o  = in_vld_q && !adv;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= RESET_PULSE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      width_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  scpd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_en_i (adv && in_q.cmd == CMD_BYTE),
    .byte_i    (in_q.rx_byte),
    .delay_q_o (delay_q),
    .sts_d_o   (ctl_d)
  );

  scpd_timer #(
    .COUNT_BITS (COUNT_BITS)
  ) u_timer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_en_i (adv && in_q.cmd == CMD_TICK),
    .zc_en_i   (adv && in_q.cmd == CMD_ZC),
    .delay_i   (delay_q),
    .width_i   (width_q),
    .sts_d_o   (tmr_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.gate        <= tmr_d.gate;
      out_q.relay_one   <= ctl_d.relay_one;
      out_q.relay_two   <= ctl_d.relay_two;
      out_q.delay_now   <= ctl_d.delay;
      out_q.firing_busy <= tmr_d.busy;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_gate_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.gate || out_data_o.firing_busy))
    else $error("gate driven while timer idle");

  a_delay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.delay_now <= FULL_SCALE))
    else $error("firing delay out of range");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && out_vld_q && out_stall_i))
    else $error("input stalled without a full pipeline");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !in_vld_q) |=> !out_valid_o)
    else $error("result repeated after transfer");
`endif

endmodule
